@@ rtl/psrc_pkg.sv @@
// Package for the printable string run counter.
// Holds shared constants, the item kind encoding and the queue entry type.
// No dependencies.
package psrc_pkg;

  localparam int unsigned RUN_WIDTH_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned TOTAL_W         = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned CFG_W           = 16;

  localparam logic [BYTE_W-1:0] PRINT_LOW     = 8'h20;
  localparam logic [BYTE_W-1:0] PRINT_HIGH    = 8'h7E;
  localparam logic [CFG_W-1:0]  MIN_RUN_RESET = 16'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA  = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_SCAN  = 2'd2
  } kind_e;

  // Classified item as it travels from front to back
  typedef struct packed {
    kind_e kind;
    logic  printable;
    logic  zero;
  } item_t;

endpackage

@@ rtl/psrc_front.sv @@
// Front end of the printable string run counter: accepts input transfers,
// classifies the byte and drops unused kinds. Depends on psrc_pkg.
module psrc_front import psrc_pkg::*; (
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              queue_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output item_t             item_o
);

  logic kind_ok;

  always_comb begin
    kind_ok = 1'b0;
    case (kind_i)
      KIND_DATA, KIND_FLUSH, KIND_SCAN: kind_ok = 1'b1;
      default: kind_ok = 1'b0;
    endcase
  end

  assign in_stall_o       = queue_full_i;
  assign push_o           = in_valid_i && !queue_full_i && kind_ok;
  assign item_o.kind      = kind_e'(kind_i);
  assign item_o.printable = byte_value_i inside {[PRINT_LOW:PRINT_HIGH]};
  assign item_o.zero      = (byte_value_i == '0);

endmodule

@@ rtl/psrc_queue.sv @@
// Short queue between front and back of the printable string run counter.
// Depends on psrc_pkg for the entry type.
module psrc_queue import psrc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  pop_valid_o,
  output item_t pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o      = (count_q == FULL);
  assign pop_valid_o = (count_q != '0);
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue popped while empty");

endmodule

@@ rtl/psrc_back.sv @@
// Back end of the printable string run counter: run detectors, totals and
// the output register. Depends on psrc_pkg.
module psrc_back import psrc_pkg::*; #(
  parameter int unsigned RUN_WIDTH = RUN_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CFG_W-1:0]   min_run_chars_i,
  input  logic               entry_valid_i,
  input  item_t              entry_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TOTAL_W-1:0] ascii_run_count_o,
  output logic [TOTAL_W-1:0] ascii_run_bytes_o,
  output logic [TOTAL_W-1:0] wide_run_count_o,
  output logic [TOTAL_W-1:0] wide_run_bytes_o
);

  logic [RUN_WIDTH-1:0] alen_q, alen_d, wlen_q, wlen_d;
  logic                 odd_q, odd_d, held_q, held_d;
  logic [TOTAL_W-1:0]   acnt_q, acnt_d, abytes_q, abytes_d;
  logic [TOTAL_W-1:0]   wcnt_q, wcnt_d, wbytes_q, wbytes_d;
  logic [TOTAL_W-1:0]   acnt_sum, abytes_sum, wcnt_sum, wbytes_sum;
  logic                 out_valid_q, out_valid_d, load_out;
  logic [TOTAL_W-1:0]   o_acnt_q, o_abytes_q, o_wcnt_q, o_wbytes_q;
  logic                 slot_free, a_qual, w_qual, a_close, w_close;
  logic [RUN_WIDTH-1:0] min_ext, alen_inc, wlen_inc;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = entry_valid_i && ((entry_i.kind != KIND_SCAN) || slot_free);

  assign min_ext  = RUN_WIDTH'(min_run_chars_i);
  assign a_qual   = (alen_q != '0) && (alen_q >= min_ext);
  assign w_qual   = (wlen_q != '0) && (wlen_q >= min_ext);
  assign alen_inc = (alen_q == '1) ? alen_q : alen_q + RUN_WIDTH'(1);
  assign wlen_inc = (wlen_q == '1) ? wlen_q : wlen_q + RUN_WIDTH'(1);

  assign acnt_sum   = acnt_q + TOTAL_W'(a_close && a_qual);
  assign abytes_sum = abytes_q + ((a_close && a_qual) ? TOTAL_W'(alen_q) : '0);
  assign wcnt_sum   = wcnt_q + TOTAL_W'(w_close && w_qual);
  assign wbytes_sum = wbytes_q + ((w_close && w_qual) ? (TOTAL_W'(wlen_q) << 1) : '0);

  always_comb begin
    alen_d      = alen_q;
    wlen_d      = wlen_q;
    odd_d       = odd_q;
    held_d      = held_q;
    a_close     = 1'b0;
    w_close     = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      case (entry_i.kind)
        KIND_DATA: begin
          if (entry_i.printable) begin
            alen_d = alen_inc;
          end else begin
            a_close = 1'b1;
          end
          if (!odd_q) begin
            held_d = entry_i.printable;
            odd_d  = 1'b1;
          end else begin
            if (held_q && entry_i.zero) begin
              wlen_d = wlen_inc;
            end else begin
              w_close = 1'b1;
            end
            held_d = 1'b0;
            odd_d  = 1'b0;
          end
        end
        KIND_FLUSH: begin
          a_close = 1'b1;
          w_close = 1'b1;
          odd_d   = 1'b0;
          held_d  = 1'b0;
        end
        KIND_SCAN: begin
          a_close     = 1'b1;
          w_close     = 1'b1;
          odd_d       = 1'b0;
          held_d      = 1'b0;
          load_out    = 1'b1;
          out_valid_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (a_close) alen_d = '0;
    if (w_close) wlen_d = '0;
    acnt_d   = load_out ? '0 : acnt_sum;
    abytes_d = load_out ? '0 : abytes_sum;
    wcnt_d   = load_out ? '0 : wcnt_sum;
    wbytes_d = load_out ? '0 : wbytes_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alen_q      <= '0;
      wlen_q      <= '0;
      odd_q       <= 1'b0;
      held_q      <= 1'b0;
      acnt_q      <= '0;
      abytes_q    <= '0;
      wcnt_q      <= '0;
      wbytes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      alen_q      <= alen_d;
      wlen_q      <= wlen_d;
      odd_q       <= odd_d;
      held_q      <= held_d;
      acnt_q      <= acnt_d;
      abytes_q    <= abytes_d;
      wcnt_q      <= wcnt_d;
      wbytes_q    <= wbytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_acnt_q   <= acnt_sum;
      o_abytes_q <= abytes_sum;
      o_wcnt_q   <= wcnt_sum;
      o_wbytes_q <= wbytes_sum;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ascii_run_count_o = o_acnt_q;
  assign ascii_run_bytes_o = o_abytes_q;
  assign wide_run_count_o  = o_wcnt_q;
  assign wide_run_bytes_o  = o_wbytes_q;

  a_scan_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.kind == KIND_SCAN) |=> out_valid_q && acnt_q == '0
      && abytes_q == '0 && wcnt_q == '0 && wbytes_q == '0)
    else $error("end of scan did not report and clear totals");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && entry_i.kind != KIND_DATA) |=> alen_q == '0 && wlen_q == '0
      && !odd_q && !held_q)
    else $error("region end left run state behind");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("pending result overwritten");

endmodule

@@ rtl/printable_string_run_counter.sv @@
// Top level of the printable string run counter.
// Instantiates psrc_front, psrc_queue and psrc_back; depends on psrc_pkg.
//
// Counts runs of printable ASCII bytes (0x20..0x7E) and of UTF-16LE
// characters (even-aligned pairs of a printable byte and a zero byte) in a
// byte stream, one byte per input transfer. A run is tallied when it ends
// if it is nonzero and at least min_run_chars long. An end-of-region item
// closes open runs and resets pair alignment; an end-of-scan item does the
// same and then gives one result with the four 64-bit totals, which are
// cleared. The block takes one item per clock while the queue is not full
// (in_stall_o low): the front classifies each byte into a queue of
// QUEUE_DEPTH entries and the back pops each entry and updates the runs
// and totals; an end-of-scan loads the totals into the output register.
// Only a result held in the output register by out_stall_i delays a
// following end-of-scan; other items keep flowing until the queue fills.
// min_run_chars resets to 4 and is written through cfg_we_i/cfg_wdata_i;
// the user must do so while the block is idle; the block does not check.
module printable_string_run_counter import psrc_pkg::*; #(
  parameter int unsigned RUN_WIDTH   = RUN_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [BYTE_W-1:0]  byte_value_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TOTAL_W-1:0] ascii_run_count_o,
  output logic [TOTAL_W-1:0] ascii_run_bytes_o,
  output logic [TOTAL_W-1:0] wide_run_count_o,
  output logic [TOTAL_W-1:0] wide_run_bytes_o
);

  logic [CFG_W-1:0] min_run_q;
  logic             push, full, pop, entry_valid;
  item_t            push_item, entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q <= MIN_RUN_RESET;
    end else if (cfg_we_i) begin
      min_run_q <= cfg_wdata_i;
    end
  end

  psrc_front u_front (
    .in_valid_i   (in_valid_i),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .queue_full_i (full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .item_o       (push_item)
  );

  psrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (entry_valid),
    .pop_item_o  (entry)
  );

  psrc_back #(
    .RUN_WIDTH (RUN_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .min_run_chars_i   (min_run_q),
    .entry_valid_i     (entry_valid),
    .entry_i           (entry),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ascii_run_count_o (ascii_run_count_o),
    .ascii_run_bytes_o (ascii_run_bytes_o),
    .wide_run_count_o  (wide_run_count_o),
    .wide_run_bytes_o  (wide_run_bytes_o)
  );

endmodule

@@ tb/tb_printable_string_run_counter.sv @@
// Testbench for printable_string_run_counter: directed and random byte streams, with
// self-checking of every end-of-scan result against a built-in model of the run scan.
// Depends on psrc_pkg and the printable_string_run_counter RTL.
`timescale 1ns / 1ps

module tb_printable_string_run_counter;
  import psrc_pkg::*;

  localparam int unsigned     TB_RUN_WIDTH = 16;
  localparam int unsigned     SETTLE       = QUEUE_DEPTH_DEF + 8;
  localparam int unsigned     RANDOM_ITEMS = 1750;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [TOTAL_W-1:0] text_count;
    logic [TOTAL_W-1:0] text_bytes;
    logic [TOTAL_W-1:0] wide_count;
    logic [TOTAL_W-1:0] wide_bytes;
  } totals_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [KIND_W-1:0]  kind_i       = KIND_DATA;
  logic [BYTE_W-1:0]  byte_value_i = '0;
  logic               cfg_we_i     = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [TOTAL_W-1:0] ascii_run_count_o;
  logic [TOTAL_W-1:0] ascii_run_bytes_o;
  logic [TOTAL_W-1:0] wide_run_count_o;
  logic [TOTAL_W-1:0] wide_run_bytes_o;

  printable_string_run_counter #(
    .RUN_WIDTH (TB_RUN_WIDTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .byte_value_i      (byte_value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .ascii_run_count_o (ascii_run_count_o),
    .ascii_run_bytes_o (ascii_run_bytes_o),
    .wide_run_count_o  (wide_run_count_o),
    .wide_run_bytes_o  (wide_run_bytes_o)
  );

  always #5 clk_i = ~clk_i;

  // Scan model state
  logic [CFG_W-1:0]        model_min;
  logic [TB_RUN_WIDTH-1:0] ascii_len;
  logic [TB_RUN_WIDTH-1:0] wide_len;
  logic                    odd_pos;
  logic                    held_printable;
  totals_t                 totals;
  totals_t                 pending_totals[$];

  int unsigned counted_items = 0;
  int unsigned fail_count    = 0;
  bit          gaps_on       = 1'b1;
  bit          stalls_on     = 1'b1;
  int unsigned stall_left    = 0;

  function automatic bit is_printable(logic [BYTE_W-1:0] b);
    return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
  endfunction

  function automatic bit run_counts(logic [TB_RUN_WIDTH-1:0] len);
    return (len != 0) && (len >= model_min);
  endfunction

  function automatic logic [TB_RUN_WIDTH-1:0] sat_next(logic [TB_RUN_WIDTH-1:0] len);
    return (len == '1) ? len : len + 1'b1;
  endfunction

  task automatic close_ascii_run();
    if (run_counts(ascii_len)) begin
      totals.text_count += 64'd1;
      totals.text_bytes += 64'(ascii_len);
    end
    ascii_len = '0;
  endtask

  task automatic close_wide_run();
    if (run_counts(wide_len)) begin
      totals.wide_count += 64'd1;
      totals.wide_bytes += 64'(wide_len) << 1;
    end
    wide_len = '0;
  endtask

  task automatic close_region();
    close_ascii_run();
    close_wide_run();
    odd_pos        = 1'b0;
    held_printable = 1'b0;
  endtask

  task automatic model_item(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b);
    if (k == KIND_DATA) begin
      if (is_printable(b)) ascii_len = sat_next(ascii_len);
      else close_ascii_run();
      if (!odd_pos) begin
        held_printable = is_printable(b);
        odd_pos        = 1'b1;
      end else begin
        if (held_printable && (b == 8'h00)) wide_len = sat_next(wide_len);
        else close_wide_run();
        held_printable = 1'b0;
        odd_pos        = 1'b0;
      end
    end else if (k == KIND_FLUSH) begin
      close_region();
    end else if (k == KIND_SCAN) begin
      close_region();
      pending_totals.push_back(totals);
      totals = '0;
    end
    if (k != KIND_UNUSED) counted_items++;
  endtask

  task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Result side: random stall between transfers, check each transfer
  always @(posedge clk_i) begin
    totals_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_totals.size() == 0) begin
        report_mismatch("unexpected result", ascii_run_count_o, '0);
      end else begin
        want = pending_totals.pop_front();
        if (ascii_run_count_o !== want.text_count)
          report_mismatch("ascii_run_count", ascii_run_count_o, want.text_count);
        if (ascii_run_bytes_o !== want.text_bytes)
          report_mismatch("ascii_run_bytes", ascii_run_bytes_o, want.text_bytes);
        if (wide_run_count_o !== want.wide_count)
          report_mismatch("wide_run_count", wide_run_count_o, want.wide_count);
        if (wide_run_bytes_o !== want.wide_bytes)
          report_mismatch("wide_run_bytes", wide_run_bytes_o, want.wide_bytes);
      end
      stall_left = stalls_on ? $urandom_range(0, 8) : 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic send_item(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    byte_value_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_item(k, b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_totals.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_min_len(logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_min    = v;
    @(posedge clk_i);
  endtask

  function automatic logic [BYTE_W-1:0] any_printable();
    return BYTE_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
  endfunction

  function automatic logic [BYTE_W-1:0] noise_byte();
    logic [BYTE_W-1:0] edges[6] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hFF};
    if ($urandom_range(0, 2) == 0) return edges[$urandom_range(0, 5)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic reset_dut();
    model_min      = MIN_RUN_RESET;
    ascii_len      = '0;
    wide_len       = '0;
    odd_pos        = 1'b0;
    held_printable = 1'b0;
    totals         = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Reset minimum of 4, byte and kind extremes, ignored kind
  task automatic test_reset_minimum();
    logic [BYTE_W-1:0] text[8] = '{"A", 8'h00, "B", 8'h00, "C", 8'h00, "D", 8'h00};
    foreach (text[i]) send_item(KIND_DATA, text[i]);
    send_item(KIND_DATA, 8'h20);
    send_item(KIND_DATA, 8'h7E);
    send_item(KIND_UNUSED, 8'hFF);
    send_item(KIND_DATA, 8'h21);
    send_item(KIND_DATA, 8'h7D);
    send_item(KIND_DATA, 8'h1F);
    send_item(KIND_DATA, 8'h7F);
    send_item(KIND_DATA, 8'hFF);
    send_item(KIND_SCAN, 8'hFF);
    wait_idle();
  endtask

  // Zero minimum: empty runs stay uncounted; odd trailing byte dropped at region end
  task automatic test_zero_minimum_alignment();
    write_min_len(16'd0);
    send_item(KIND_SCAN, 8'h00);
    send_item(KIND_DATA, "A");
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, "B");
    send_item(KIND_FLUSH, 8'hAA);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, "C");
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_FLUSH, 8'h55);
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_SCAN, 8'h00);
    wait_idle();
  endtask

  task automatic test_random_scans();
    int unsigned phase = 0;
    int unsigned phase_end;
    int unsigned n;
    int unsigned pick;
    logic [CFG_W-1:0] min_v;
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (phase == 0) min_v = 16'd0;
      else if (phase == 1) min_v = 16'hFFFF;
      else if (pick < 14) min_v = CFG_W'($urandom_range(1, 6));
      else if (pick < 17) min_v = 16'd0;
      else if (pick < 19) min_v = CFG_W'($urandom_range(0, 65535));
      else min_v = 16'hFFFF;
      write_min_len(min_v);
      gaps_on   = (phase % 3) != 2;
      stalls_on = (phase % 4) != 3;
      phase_end = counted_items + $urandom_range(100, 200);
      while (counted_items < phase_end) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          n = $urandom_range(0, 10);
          repeat (n) send_item(KIND_DATA, any_printable());
          send_item(KIND_DATA, noise_byte());
        end else if (pick < 11) begin
          if (odd_pos) send_item(KIND_DATA, noise_byte());
          n = $urandom_range(0, 8);
          repeat (n) begin
            send_item(KIND_DATA, any_printable());
            send_item(KIND_DATA, 8'h00);
          end
        end else if (pick < 14) begin
          send_item(KIND_DATA, noise_byte());
        end else if (pick < 16) begin
          send_item(KIND_FLUSH, BYTE_W'($urandom_range(0, 255)));
        end else if (pick == 16) begin
          send_item(KIND_DATA, $urandom_range(0, 1) ? any_printable() : 8'h00);
          send_item(KIND_DATA, $urandom_range(0, 1) ? any_printable() : noise_byte());
        end else if (pick == 17) begin
          send_item(KIND_UNUSED, BYTE_W'($urandom_range(0, 255)));
        end else begin
          send_item(KIND_SCAN, BYTE_W'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) == 0) wait_idle();
        end
      end
      send_item(KIND_SCAN, BYTE_W'($urandom_range(0, 255)));
      wait_idle();
      phase++;
    end
  endtask

  initial begin
    reset_dut();
    test_reset_minimum();
    test_zero_minimum_alignment();
    test_random_scans();
    wait_idle();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/psrc_pkg.sv
rtl/psrc_front.sv
rtl/psrc_queue.sv
rtl/psrc_back.sv
rtl/printable_string_run_counter.sv
tb/tb_printable_string_run_counter.sv
